// ----- rtl/core/dhv_pkg.sv -----
// ----------------------------------------------------------------------------
// dhv_pkg
// Shared types and constants for the host name checker.
// ----------------------------------------------------------------------------
package dhv_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] MAX_NAME_RESET = 8'd253;
  localparam logic [6:0] LABEL_MAX      = 7'd63;
  localparam logic [8:0] BYTE_SAT       = 9'd511;
  localparam logic [6:0] LABEL_SAT      = 7'd127;

  localparam logic [7:0] CHAR_DOT    = 8'h2e;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2d;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
  localparam logic [7:0] CHAR_DIG_0  = 8'h30;
  localparam logic [7:0] CHAR_DIG_9  = 8'h39;

  typedef struct packed {
    logic last;
    logic is_dot;
    logic is_hyphen;
    logic bad_char;
  } byte_class_t;

endpackage

// ----- rtl/core/dns_hostname_validator_core.sv -----
// ----------------------------------------------------------------------------
// dns_hostname_validator_core
// Checks a streamed host name and gives one verdict per name.
//
// Input channel: name_byte and last_byte, one word per cycle, moved by
// byte_valid / byte_stall. Output channel: name_ok, moved by
// result_valid / result_stall, one word per name, on its final byte only.
// cfg_we writes cfg_wdata into the maximum name length (reset 253).
// Throughput is one byte per cycle while byte_stall is low. The final
// byte's class word enters the queue when that byte is taken, and the
// verdict is loaded into the output register when the back part pops it.
// When result_stall holds, the verdict stays put; the back part then halts
// on the next final byte and the queue fills to QUEUE_DEPTH words, that
// final byte among them, before byte_stall rises.
// Synchronous reset empties the queue, clears the name counters and
// result_valid, and restores the maximum length to 253.
// ----------------------------------------------------------------------------
module dns_hostname_validator_core #(
  parameter int unsigned QUEUE_DEPTH = dhv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] name_byte,
  input  logic       last_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       name_ok
);

  logic                 queue_full;
  logic                 queue_empty;
  logic                 push;
  logic                 pop;
  dhv_pkg::byte_class_t push_word;
  dhv_pkg::byte_class_t pop_word;

  dhv_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .name_byte  (name_byte),
    .last_byte  (last_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_word  (push_word)
  );

  dhv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (queue_empty)
  );

  dhv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .queue_empty  (queue_empty),
    .head         (pop_word),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .name_ok      (name_ok)
  );

endmodule

// ----- rtl/core/dhv_front.sv -----
// ----------------------------------------------------------------------------
// dhv_front
// Accepts name bytes and sorts each into a class word for the queue.
// ----------------------------------------------------------------------------
module dhv_front (
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           name_byte,
  input  logic                 last_byte,
  input  logic                 queue_full,
  output logic                 push,
  output dhv_pkg::byte_class_t push_word
);

  logic lower;
  logic digit;
  logic hyphen;
  logic dot;

  always_comb begin
    lower  = (name_byte >= dhv_pkg::CHAR_LOW_A) && (name_byte <= dhv_pkg::CHAR_LOW_Z);
    digit  = (name_byte >= dhv_pkg::CHAR_DIG_0) && (name_byte <= dhv_pkg::CHAR_DIG_9);
    hyphen = (name_byte == dhv_pkg::CHAR_HYPHEN);
    dot    = (name_byte == dhv_pkg::CHAR_DOT);
  end

  assign byte_stall = queue_full;
  assign push       = byte_valid && !queue_full;

  always_comb begin
    push_word.last      = last_byte;
    push_word.is_dot    = dot;
    push_word.is_hyphen = hyphen;
    push_word.bad_char  = !(lower || digit || hyphen || dot);
  end

endmodule

// ----- rtl/core/dhv_queue.sv -----
// ----------------------------------------------------------------------------
// dhv_queue
// Short queue of class words between the front and back parts.
// ----------------------------------------------------------------------------
module dhv_queue #(
  parameter int unsigned DEPTH = dhv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dhv_pkg::byte_class_t push_word,
  output logic                 full,
  input  logic                 pop,
  output dhv_pkg::byte_class_t pop_word,
  output logic                 empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dhv_pkg::byte_class_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("queue read while empty");

endmodule

// ----- rtl/core/dhv_back.sv -----
// ----------------------------------------------------------------------------
// dhv_back
// Tracks counters and label rules per name and registers the verdict.
// ----------------------------------------------------------------------------
module dhv_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 queue_empty,
  input  dhv_pkg::byte_class_t head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 name_ok
);

  logic [7:0] max_name_bytes;
  logic [8:0] byte_count;
  logic [6:0] label_count;
  logic       prev_was_hyphen;
  logic       seen_bad;

  logic [8:0] byte_count_next;
  logic [6:0] label_count_next;
  logic       prev_was_hyphen_next;
  logic       seen_bad_next;
  logic [6:0] label_inc;
  logic       slot_free;
  logic       ok_next;

  assign slot_free = !result_valid || !result_stall;
  assign pop       = !queue_empty && (!head.last || slot_free);

  always_comb begin
    byte_count_next = (byte_count < dhv_pkg::BYTE_SAT) ? byte_count + 1'b1 : byte_count;
    label_inc = (label_count < dhv_pkg::LABEL_SAT) ? label_count + 1'b1 : label_count;
    seen_bad_next = seen_bad;
    if (head.is_dot) begin
      if ((label_count == '0) || (label_count > dhv_pkg::LABEL_MAX) || prev_was_hyphen
          || head.last) begin
        seen_bad_next = 1'b1;
      end
      label_count_next     = '0;
      prev_was_hyphen_next = 1'b0;
    end else begin
      if (head.bad_char || (head.is_hyphen && (label_count == '0))) begin
        seen_bad_next = 1'b1;
      end
      if (head.last && ((label_inc > dhv_pkg::LABEL_MAX) || head.is_hyphen)) begin
        seen_bad_next = 1'b1;
      end
      label_count_next     = label_inc;
      prev_was_hyphen_next = head.is_hyphen;
    end
    ok_next = !seen_bad_next && (byte_count_next <= {1'b0, max_name_bytes});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_bytes <= dhv_pkg::MAX_NAME_RESET;
    end else if (cfg_we) begin
      max_name_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      label_count     <= '0;
      prev_was_hyphen <= 1'b0;
      seen_bad        <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        byte_count      <= '0;
        label_count     <= '0;
        prev_was_hyphen <= 1'b0;
        seen_bad        <= 1'b0;
      end else begin
        byte_count      <= byte_count_next;
        label_count     <= label_count_next;
        prev_was_hyphen <= prev_was_hyphen_next;
        seen_bad        <= seen_bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && head.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      name_ok <= ok_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (byte_count == '0) && (label_count == '0) && !seen_bad)
    else $error("name state not cleared after final word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(pop && head.last))
    else $error("verdict overwritten while held");

endmodule

// ----- tb/sv/dhv_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhv_checker
// Follows both channels and the length register of the host name checker.
// It keeps its own copy of the per-name counters, works out the verdict of
// each name on its final byte and compares every verdict that the block
// hands out against the oldest one still owed.
// ----------------------------------------------------------------------------
module dhv_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  logic [7:0] name_byte,
  input  logic       last_byte,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic       name_ok,
  output int         mismatches,
  output int         pending
);

  logic [7:0] max_len;
  logic [8:0] name_len;
  logic [6:0] label_len;
  logic       hyph_tail;
  logic       name_bad;
  logic       verdict_q[$];
  logic       want;

  task automatic clear_name();
    name_len  = '0;
    label_len = '0;
    hyph_tail = 1'b0;
    name_bad  = 1'b0;
  endtask

  task automatic end_label();
    if (label_len == '0 || label_len > dhv_pkg::LABEL_MAX || hyph_tail) begin
      name_bad = 1'b1;
    end
    label_len = '0;
    hyph_tail = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] c, input logic fin);
    logic hyph;
    logic legal;
    hyph  = (c == dhv_pkg::CHAR_HYPHEN);
    legal = (c >= dhv_pkg::CHAR_LOW_A && c <= dhv_pkg::CHAR_LOW_Z)
            || (c >= dhv_pkg::CHAR_DIG_0 && c <= dhv_pkg::CHAR_DIG_9)
            || hyph;
    if (name_len != dhv_pkg::BYTE_SAT) begin
      name_len = name_len + 9'd1;
    end
    if (c == dhv_pkg::CHAR_DOT) begin
      end_label();
      if (fin) begin
        name_bad = 1'b1;
      end
    end else begin
      if (!legal || (hyph && label_len == '0)) begin
        name_bad = 1'b1;
      end
      if (label_len != dhv_pkg::LABEL_SAT) begin
        label_len = label_len + 7'd1;
      end
      hyph_tail = hyph;
      if (fin) begin
        end_label();
      end
    end
    if (fin) begin
      verdict_q.insert(verdict_q.size(), !name_bad && name_len <= {1'b0, max_len});
      clear_name();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      max_len = dhv_pkg::MAX_NAME_RESET;
      clear_name();
      verdict_q.delete();
    end else begin
      if (cfg_we) begin
        max_len = cfg_wdata;
      end
      if (byte_valid && !byte_stall) begin
        absorb_byte(name_byte, last_byte);
      end
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: verdict %b with no name pending", $realtime, name_ok);
          end
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (name_ok !== want) begin
            if (mismatches < 10) begin
              $display("%0t: name_ok expected %b got %b", $realtime, want, name_ok);
            end
            mismatches++;
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ----- tb/sv/tb_dns_hostname_validator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_hostname_validator_core
// Streams host names into the checker core under random gaps and output
// stalls, with one long output hold-off, across several length limits.
// Directed names cover single bytes, empty labels, edge hyphens, label and
// total length limits and counter saturation; random names follow, mostly
// well formed, some broken, some noise. dhv_checker scores every verdict.
// ----------------------------------------------------------------------------
module tb_dns_hostname_validator_core;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = '0;
  logic       byte_valid   = 1'b0;
  logic       byte_stall;
  logic [7:0] name_byte    = '0;
  logic       last_byte    = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       name_ok;

  int         mismatches;
  int         pending;
  int         cycles        = 0;
  int         sent          = 0;
  logic       sender_idles   = 1'b1;
  logic       receiver_idles = 1'b1;
  logic       hold_go        = 1'b0;
  logic [7:0] cur_max        = dhv_pkg::MAX_NAME_RESET;
  logic [7:0] name_q[$];

  always #4 clk = ~clk;

  dns_hostname_validator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .name_byte    (name_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .name_ok      (name_ok)
  );

  dhv_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .name_byte    (name_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .name_ok      (name_ok),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold the output off for a long stretch on request, else stall at random while receiver_idles is set
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HOLD_CYCLES) begin
          result_stall <= 1'b1;
          @(posedge clk);
        end
      end
      result_stall <= receiver_idles && ($urandom_range(0, 99) < 8);
    end
  end

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 35);
    return (r < 26) ? dhv_pkg::CHAR_LOW_A + 8'(r) : dhv_pkg::CHAR_DIG_0 + 8'(r - 26);
  endfunction

  // append a label with no edge hyphens, with a separating dot when the name already has bytes
  task automatic add_label(input int len);
    if (name_q.size() != 0) begin
      name_q.insert(name_q.size(), dhv_pkg::CHAR_DOT);
    end
    for (int i = 0; i < len; i++) begin
      if (i == 0 || i == len - 1 || $urandom_range(0, 3) != 0) begin
        name_q.insert(name_q.size(), pick_alnum());
      end else begin
        name_q.insert(name_q.size(), dhv_pkg::CHAR_HYPHEN);
      end
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic fin);
    while (sender_idles && $urandom_range(0, 99) < 8) begin
      byte_valid <= 1'b0;
      name_byte  <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    name_byte  <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (byte_stall) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic send_name();
    for (int i = 0; i < name_q.size(); i++) begin
      send_word(name_q[i], i == name_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    name_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      name_q.insert(name_q.size(), s[i]);
    end
    send_name();
  endtask

  task automatic send_byte_name(input logic [7:0] b);
    name_q.delete();
    name_q.insert(name_q.size(), b);
    send_name();
  endtask

  task automatic make_random_name();
    int kind;
    int nlab;
    int len;
    int rem;
    int pos;
    name_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 2) begin
      // total length right at the limit or one past it
      rem = int'(cur_max) + $urandom_range(0, 1);
      if (rem == 0) begin
        rem = 1;
      end
      while (rem > 0) begin
        if (name_q.size() != 0) begin
          rem--;
        end
        len = $urandom_range(1, 63);
        if (len >= rem) begin
          len = rem;
        end else if (rem - len == 1) begin
          len = (len == 63) ? 62 : len + 1;
        end
        add_label(len);
        rem -= len;
      end
    end else if (kind < 90) begin
      nlab = $urandom_range(1, 4);
      repeat (nlab) begin
        add_label(($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 6));
      end
      if (kind >= 67) begin
        pos = $urandom_range(0, name_q.size() - 1);
        case ($urandom_range(0, 6))
          0: name_q[pos] = 8'($urandom_range(0, 255));
          1: name_q.push_front(dhv_pkg::CHAR_DOT);
          2: name_q.insert(name_q.size(), dhv_pkg::CHAR_DOT);
          3: begin
            name_q[pos] = dhv_pkg::CHAR_DOT;
            if (pos + 1 < name_q.size()) begin
              name_q[pos + 1] = dhv_pkg::CHAR_DOT;
            end
          end
          4: name_q.push_front(dhv_pkg::CHAR_HYPHEN);
          5: name_q.insert(name_q.size(), dhv_pkg::CHAR_HYPHEN);
          default: name_q[pos] = 8'($urandom_range(65, 90));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 6)) begin
        name_q.insert(name_q.size(), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic random_names(input int nbytes);
    int start;
    start = sent;
    while (sent - start < nbytes) begin
      make_random_name();
      send_name();
    end
  endtask

  // drop valid, wait out every verdict, then let the pipeline settle
  task automatic finish_phase();
    byte_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_max = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("a");
    send_text("z9");
    send_text("0");
    send_text("-");
    send_text(".");
    send_text("a.");
    send_text(".a");
    send_text("a..b");
    send_text("a-b");
    send_text("ab-");
    send_text("A");
    send_byte_name(8'h00);
    send_byte_name(8'hff);
    send_text("a.b");

    name_q.delete();
    add_label(63);
    send_name();
    name_q.delete();
    add_label(64);
    send_name();
    name_q.delete();
    add_label(130);
    send_name();
    name_q.delete();
    add_label(62);
    add_label(62);
    add_label(63);
    add_label(63);
    send_name();
    name_q.delete();
    repeat (9) add_label(57);
    send_name();
    finish_phase();

    write_max(8'd255);
    random_names(60);
    finish_phase();

    write_max(8'd0);
    random_names(30);
    finish_phase();

    write_max(8'd1);
    random_names(30);
    finish_phase();

    write_max(8'd63);
    random_names(50);
    finish_phase();

    write_max(8'($urandom_range(2, 254)));
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_go        = 1'b1;
    random_names(120);
    finish_phase();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    write_max(dhv_pkg::MAX_NAME_RESET);
    random_names(40);
    finish_phase();

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
